[hw/rtl/tccc_pkg.sv]
`default_nettype none

package tccc_pkg;

   localparam int GLYPH_WIDTH_DEFAULT  = 8;
   localparam int GLYPH_HEIGHT_DEFAULT = 16;

   localparam int COORD_W = 12;
   localparam int CHAR_W  = 8;
   localparam int CODE_W  = 7;
   localparam int COLOR_W = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_LO  = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_HI  = 8'd126;

   localparam logic [COORD_W-1:0] AREA_WIDTH_RESET  = 12'd640;
   localparam logic [COORD_W-1:0] AREA_HEIGHT_RESET = 12'd480;
   localparam logic [COORD_W-1:0] ORIGIN_X_RESET    = 12'd0;
   localparam logic [COORD_W-1:0] ORIGIN_Y_RESET    = 12'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AREA_WIDTH  = 2'd0,
      CSR_AREA_HEIGHT = 2'd1,
      CSR_ORIGIN_X    = 2'd2,
      CSR_ORIGIN_Y    = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_DRAW   = 1'b0,
      CMD_SCROLL = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      logic [COORD_W-1:0] area_width;
      logic [COORD_W-1:0] area_height;
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [CODE_W-1:0]  code;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COLOR_W-1:0] color;
      logic               last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_type;

endpackage

`default_nettype wire

[hw/rtl/tccc_cursor.sv]
`default_nettype none

module tccc_cursor #(
   parameter int GLYPH_WIDTH  = tccc_pkg::GLYPH_WIDTH_DEFAULT,
   parameter int GLYPH_HEIGHT = tccc_pkg::GLYPH_HEIGHT_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         go,
   input  wire logic [tccc_pkg::CHAR_W-1:0]  char_code,
   input  wire logic [tccc_pkg::COLOR_W-1:0] ink_color,
   input  wire tccc_pkg::cfg_type            cfg,
   output tccc_pkg::step_type                step
);

   logic [tccc_pkg::COORD_W-1:0] col_ff, col_in;
   logic [tccc_pkg::COORD_W-1:0] row_ff, row_in;
   logic [tccc_pkg::COORD_W:0]   adv_col;
   logic [tccc_pkg::COORD_W:0]   nl_next_row;
   logic [tccc_pkg::COORD_W+1:0] nl_bottom;
   logic                         nl_scroll;
   logic                         printable;
   tccc_pkg::result_type         draw_res;
   tccc_pkg::result_type         scroll_res;

   assign adv_col     = {1'b0, col_ff} + (tccc_pkg::COORD_W+1)'(GLYPH_WIDTH);
   assign nl_next_row = {1'b0, row_ff} + (tccc_pkg::COORD_W+1)'(GLYPH_HEIGHT);
   assign nl_bottom   = {1'b0, nl_next_row} + (tccc_pkg::COORD_W+2)'(GLYPH_HEIGHT);
   assign nl_scroll   = nl_bottom >= {2'b00, cfg.area_height};
   assign printable   = (char_code >= tccc_pkg::CHAR_PRINT_LO) &&
                        (char_code <= tccc_pkg::CHAR_PRINT_HI);

   always_comb begin
      draw_res.kind  = tccc_pkg::CMD_DRAW;
      draw_res.code  = char_code[tccc_pkg::CODE_W-1:0];
      draw_res.x     = col_ff;
      draw_res.y     = row_ff;
      draw_res.color = ink_color;
      draw_res.last  = 1'b1;

      scroll_res.kind  = tccc_pkg::CMD_SCROLL;
      scroll_res.code  = '0;
      scroll_res.x     = cfg.origin_x;
      scroll_res.y     = row_ff;
      scroll_res.color = '0;
      scroll_res.last  = 1'b1;
   end

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      step.count  = 2'd0;
      step.first  = draw_res;
      step.second = scroll_res;
      priority if (char_code == tccc_pkg::CHAR_BACKSPACE) begin
         if (col_ff >= tccc_pkg::COORD_W'(GLYPH_WIDTH)) begin
            col_in = col_ff - tccc_pkg::COORD_W'(GLYPH_WIDTH);
         end else if (row_ff >= tccc_pkg::COORD_W'(GLYPH_HEIGHT)) begin
            col_in = cfg.area_width - tccc_pkg::COORD_W'(GLYPH_WIDTH);
            row_in = row_ff - tccc_pkg::COORD_W'(GLYPH_HEIGHT);
         end
      end else if (char_code == tccc_pkg::CHAR_NEWLINE) begin
         col_in = cfg.origin_x;
         if (nl_scroll) begin
            step.count = 2'd1;
            step.first = scroll_res;
         end else begin
            row_in = nl_next_row[tccc_pkg::COORD_W-1:0];
         end
      end else if (char_code == tccc_pkg::CHAR_RETURN) begin
         col_in = cfg.origin_x;
      end else if (printable) begin
         step.count = 2'd1;
         if (adv_col >= {1'b0, cfg.area_width}) begin
            col_in = cfg.origin_x;
            if (nl_scroll) begin
               step.count      = 2'd2;
               step.first.last = 1'b0;
            end else begin
               row_in = nl_next_row[tccc_pkg::COORD_W-1:0];
            end
         end else begin
            col_in = adv_col[tccc_pkg::COORD_W-1:0];
         end
      end else begin
         // other codes leave the cursor where it is
         col_in = col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= tccc_pkg::ORIGIN_X_RESET;
         row_ff <= tccc_pkg::ORIGIN_Y_RESET;
      end else if (go) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/tccc_rsp_stage.sv]
`default_nettype none

module tccc_rsp_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               go,
   input  wire tccc_pkg::step_type step,
   output logic                    can_take,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output tccc_pkg::result_type    rsp_item
);

   logic                 out_valid_ff, out_valid_in;
   logic                 pend_valid_ff, pend_valid_in;
   tccc_pkg::result_type out_ff, out_in;
   tccc_pkg::result_type pend_ff, pend_in;
   logic                 pop;

   assign pop       = out_valid_ff && !rsp_stall;
   assign can_take  = (!out_valid_ff || !rsp_stall) && !pend_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      pend_in       = pend_ff;
      if (go && step.count != 2'd0) begin
         out_valid_in  = 1'b1;
         out_in        = step.first;
         pend_valid_in = step.count == 2'd2;
         pend_in       = step.second;
      end else if (pop && pend_valid_ff) begin
         out_in        = pend_ff;
         pend_valid_in = 1'b0;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

endmodule

`default_nettype wire

[hw/rtl/text_console_cursor_control_core.sv]
// Text console cursor control core
//
// req channel: one character byte and an ink color per item, taken at a clock
// edge with req_valid high and req_stall low. Each item yields zero, one or two
// rsp items (draw glyph, scroll up one row); rsp_last_command marks the final one.
// Control codes that only move the cursor, and unknown codes, give no rsp item.
//
// An item is held in the input register, and its first rsp item is then shown from the
// rsp register. Throughput: one item per cycle while each item gives at most one rsp
// item and rsp_stall is low; an item that gives two holds the input while the second
// result waits in the pending register behind the rsp register.
// A held rsp item stays stable while rsp_stall is high; the input register then
// fills and req_stall rises.
//
// csr port: csr_write with csr_index selects area width, area height, origin x,
// origin y; write only while the block is idle. Reset (synchronous) empties all
// stages, restores the register defaults (640 x 480, origin 0,0) and puts the
// cursor at the origin.
`default_nettype none

module text_console_cursor_control_core #(
   parameter int GLYPH_WIDTH  = tccc_pkg::GLYPH_WIDTH_DEFAULT,
   parameter int GLYPH_HEIGHT = tccc_pkg::GLYPH_HEIGHT_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [tccc_pkg::CHAR_W-1:0]    req_char_code,
   input  wire logic [tccc_pkg::COLOR_W-1:0]   req_ink_color,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_command_kind,
   output logic [tccc_pkg::CODE_W-1:0]         rsp_glyph_code,
   output logic [tccc_pkg::COORD_W-1:0]        rsp_pos_x,
   output logic [tccc_pkg::COORD_W-1:0]        rsp_pos_y,
   output logic [tccc_pkg::COLOR_W-1:0]        rsp_glyph_color,
   output logic                                rsp_last_command,
   input  wire logic                           csr_write,
   input  wire logic [tccc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tccc_pkg::COORD_W-1:0]   csr_wdata
);

   tccc_pkg::cfg_type            cfg_ff, cfg_in;
   logic                         in_valid_ff, in_valid_in;
   logic [tccc_pkg::CHAR_W-1:0]  in_char_ff, in_char_in;
   logic [tccc_pkg::COLOR_W-1:0] in_color_ff, in_color_in;
   logic                         can_take;
   logic                         go;
   logic                         req_take;
   tccc_pkg::step_type           step;
   tccc_pkg::result_type         rsp_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (tccc_pkg::csr_index_type'(csr_index))
            tccc_pkg::CSR_AREA_WIDTH:  cfg_in.area_width  = csr_wdata;
            tccc_pkg::CSR_AREA_HEIGHT: cfg_in.area_height = csr_wdata;
            tccc_pkg::CSR_ORIGIN_X:    cfg_in.origin_x    = csr_wdata;
            tccc_pkg::CSR_ORIGIN_Y:    cfg_in.origin_y    = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.area_width  <= tccc_pkg::AREA_WIDTH_RESET;
         cfg_ff.area_height <= tccc_pkg::AREA_HEIGHT_RESET;
         cfg_ff.origin_x    <= tccc_pkg::ORIGIN_X_RESET;
         cfg_ff.origin_y    <= tccc_pkg::ORIGIN_Y_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register
   assign go        = in_valid_ff && can_take;
   assign req_stall = in_valid_ff && !can_take;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_color_in = in_color_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_char_in  = req_char_code;
         in_color_in = req_ink_color;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff  <= in_char_in;
      in_color_ff <= in_color_in;
   end

   tccc_cursor #(
      .GLYPH_WIDTH  (GLYPH_WIDTH),
      .GLYPH_HEIGHT (GLYPH_HEIGHT)
   ) u_cursor (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .char_code (in_char_ff),
      .ink_color (in_color_ff),
      .cfg       (cfg_ff),
      .step      (step)
   );

   tccc_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .step      (step),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_command_kind = rsp_item.kind;
   assign rsp_glyph_code   = rsp_item.code;
   assign rsp_pos_x        = rsp_item.x;
   assign rsp_pos_y        = rsp_item.y;
   assign rsp_glyph_color  = rsp_item.color;
   assign rsp_last_command = rsp_item.last;

endmodule

`default_nettype wire

[hw/rtl/tccc_checker.sv]
`default_nettype none

module tccc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic                           rsp_command_kind,
   input wire logic [tccc_pkg::CODE_W-1:0]    rsp_glyph_code,
   input wire logic [tccc_pkg::COORD_W-1:0]   rsp_pos_x,
   input wire logic [tccc_pkg::COORD_W-1:0]   rsp_pos_y,
   input wire logic [tccc_pkg::COLOR_W-1:0]   rsp_glyph_color,
   input wire logic                           rsp_last_command
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp item shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command_kind) &&
         $stable(rsp_glyph_code) && $stable(rsp_pos_x) && $stable(rsp_pos_y) &&
         $stable(rsp_glyph_color) && $stable(rsp_last_command))
      else $error("stalled rsp item changed");

   a_scroll_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_kind == tccc_pkg::CMD_SCROLL |->
         rsp_last_command && rsp_glyph_code == '0 && rsp_glyph_color == '0)
      else $error("scroll item not final or carries glyph data");

   a_draw_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_kind == tccc_pkg::CMD_DRAW |->
         rsp_glyph_code >= tccc_pkg::CHAR_PRINT_LO[tccc_pkg::CODE_W-1:0] &&
         rsp_glyph_code <= tccc_pkg::CHAR_PRINT_HI[tccc_pkg::CODE_W-1:0])
      else $error("draw item with non-printable code");

   a_follow_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_command |=> rsp_valid)
      else $error("second rsp item of an item missing");

endmodule

bind text_console_cursor_control_core tccc_checker u_tccc_checker (.*);

`default_nettype wire

[sim/tb_text_console_cursor_control_checker.sv]
`timescale 1ns / 1ps

module tb_text_console_cursor_control_checker
   import tccc_pkg::*;
#(
   parameter int GLYPH_W = GLYPH_WIDTH_DEFAULT,
   parameter int GLYPH_H = GLYPH_HEIGHT_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic [COLOR_W-1:0]   req_ink_color,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_command_kind,
   input  logic [CODE_W-1:0]    rsp_glyph_code,
   input  logic [COORD_W-1:0]   rsp_pos_x,
   input  logic [COORD_W-1:0]   rsp_pos_y,
   input  logic [COLOR_W-1:0]   rsp_glyph_color,
   input  logic                 rsp_last_command,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata,
   output int                   mismatches,
   output int                   cmds_due
);

   logic [COORD_W-1:0] area_w;
   logic [COORD_W-1:0] area_h;
   logic [COORD_W-1:0] org_x;
   logic [COORD_W-1:0] org_y;
   logic [COORD_W-1:0] col_px;
   logic [COORD_W-1:0] row_px;
   result_type         console_cmds[$];

   function automatic result_type make_cmd(input cmd_kind_type kind,
                                           input logic [CODE_W-1:0] code,
                                           input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y,
                                           input logic [COLOR_W-1:0] color);
      result_type r;
      r.kind = kind;
      r.code = code;
      r.x = x;
      r.y = y;
      r.color = color;
      r.last = 1'b0;
      return r;
   endfunction

   // new line; scrolls instead when the next row would reach the bottom
   task automatic line_feed();
      int next_row;
      next_row = int'(row_px) + GLYPH_H;
      col_px = org_x;
      if (next_row + GLYPH_H >= int'(area_h)) begin
         console_cmds.push_back(make_cmd(CMD_SCROLL, '0, org_x, row_px, '0));
      end else begin
         row_px = COORD_W'(next_row);
      end
   endtask

   task automatic advance_cursor(input logic [CHAR_W-1:0] code,
                                 input logic [COLOR_W-1:0] color);
      int queued;
      int next_col;
      queued = console_cmds.size();
      if (code == CHAR_BACKSPACE) begin
         if (int'(col_px) >= GLYPH_W) begin
            col_px = col_px - COORD_W'(GLYPH_W);
         end else if (int'(row_px) >= GLYPH_H) begin
            col_px = area_w - COORD_W'(GLYPH_W);
            row_px = row_px - COORD_W'(GLYPH_H);
         end
      end else if (code == CHAR_NEWLINE) begin
         line_feed();
      end else if (code == CHAR_RETURN) begin
         col_px = org_x;
      end else if (code >= CHAR_PRINT_LO && code <= CHAR_PRINT_HI) begin
         console_cmds.push_back(make_cmd(CMD_DRAW, code[CODE_W-1:0], col_px, row_px, color));
         next_col = int'(col_px) + GLYPH_W;
         if (next_col >= int'(area_w)) begin
            line_feed();
         end else begin
            col_px = COORD_W'(next_col);
         end
      end
      if (console_cmds.size() > queued) begin
         console_cmds[console_cmds.size() - 1].last = 1'b1;
      end
   endtask

   task automatic check_field(input string name, input logic [COLOR_W-1:0] want,
                              input logic [COLOR_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_cmd();
      result_type want;
      if (console_cmds.size() == 0) begin
         $display("%0t ns: unexpected rsp item kind %0d code %0h x %0h y %0h",
                  $time, rsp_command_kind, rsp_glyph_code, rsp_pos_x, rsp_pos_y);
         mismatches++;
      end else begin
         want = console_cmds.pop_front();
         check_field("command_kind", 32'(want.kind), 32'(rsp_command_kind));
         check_field("glyph_code", 32'(want.code), 32'(rsp_glyph_code));
         check_field("pos_x", 32'(want.x), 32'(rsp_pos_x));
         check_field("pos_y", 32'(want.y), 32'(rsp_pos_y));
         check_field("glyph_color", want.color, rsp_glyph_color);
         check_field("last_command", 32'(want.last), 32'(rsp_last_command));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         area_w = AREA_WIDTH_RESET;
         area_h = AREA_HEIGHT_RESET;
         org_x = ORIGIN_X_RESET;
         org_y = ORIGIN_Y_RESET;
         col_px = ORIGIN_X_RESET;
         row_px = ORIGIN_Y_RESET;
         console_cmds.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_AREA_WIDTH: area_w = csr_wdata;
               CSR_AREA_HEIGHT: area_h = csr_wdata;
               CSR_ORIGIN_X: org_x = csr_wdata;
               CSR_ORIGIN_Y: org_y = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            check_cmd();
         end
         if (req_valid && !req_stall) begin
            advance_cursor(req_char_code, req_ink_color);
         end
      end
      cmds_due <= console_cmds.size();
   end

endmodule

[sim/tb_text_console_cursor_control_core.sv]
`timescale 1ns / 1ps

module tb_text_console_cursor_control_core;
   import tccc_pkg::*;

   localparam int HOLD_CYCLES = 60;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [CHAR_W-1:0]    req_char_code;
   logic [COLOR_W-1:0]   req_ink_color;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_command_kind;
   logic [CODE_W-1:0]    rsp_glyph_code;
   logic [COORD_W-1:0]   rsp_pos_x;
   logic [COORD_W-1:0]   rsp_pos_y;
   logic [COLOR_W-1:0]   rsp_glyph_color;
   logic                 rsp_last_command;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0]   csr_wdata;

   int mismatches;
   int cmds_due;
   bit send_calm;
   bit recv_calm;
   int holds_asked;
   int holds_done;

   text_console_cursor_control_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_code(req_char_code),
      .req_ink_color(req_ink_color),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_command_kind(rsp_command_kind),
      .rsp_glyph_code(rsp_glyph_code),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_glyph_color(rsp_glyph_color),
      .rsp_last_command(rsp_last_command),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   tb_text_console_cursor_control_checker checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_code(req_char_code),
      .req_ink_color(req_ink_color),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_command_kind(rsp_command_kind),
      .rsp_glyph_code(rsp_glyph_code),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_glyph_color(rsp_glyph_color),
      .rsp_last_command(rsp_last_command),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatches(mismatches),
      .cmds_due(cmds_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("FAIL text_console_cursor_control_core");
      $finish;
   end

   // receiving side
   initial begin
      holds_done = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !recv_calm && ($urandom_range(99) < 8);
      end
   end

   task automatic send_char(input logic [CHAR_W-1:0] code, input logic [COLOR_W-1:0] color);
      if (!send_calm && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= code;
      req_ink_color <= color;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop offering and let every pending command come out
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (cmds_due != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_cfg(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                            input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy);
      csr_write <= 1'b1;
      csr_index <= CSR_AREA_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_AREA_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= CSR_ORIGIN_X;
      csr_wdata <= ox;
      @(posedge clock);
      csr_index <= CSR_ORIGIN_Y;
      csr_wdata <= oy;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [CHAR_W-1:0] pick_char();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return CHAR_W'($urandom_range(CHAR_PRINT_HI, CHAR_PRINT_LO));
      if (roll < 67) return CHAR_NEWLINE;
      if (roll < 80) return CHAR_BACKSPACE;
      if (roll < 86) return CHAR_RETURN;
      return CHAR_W'($urandom_range(255, 0));
   endfunction

   initial begin
      int n_items;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      logic [COORD_W-1:0] ox;
      logic [COORD_W-1:0] oy;

      send_calm = 1'b0;
      recv_calm = 1'b0;
      holds_asked = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_char_code <= '0;
      req_ink_color <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_AREA_WIDTH;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, default area
      send_char(CHAR_BACKSPACE, 32'h0);
      send_char(CHAR_PRINT_LO, 32'h0000_0000);
      send_char(CHAR_PRINT_HI, 32'hFFFF_FFFF);
      send_char(CHAR_BACKSPACE, 32'h0);
      send_char(8'd0, 32'hFFFF_FFFF);
      send_char(8'd31, 32'h0);
      send_char(8'd127, 32'h0);
      send_char(8'd128, 32'h0);
      send_char(8'd255, 32'hFFFF_FFFF);
      send_char(8'd9, 32'h0);
      send_char(CHAR_RETURN, 32'h0);
      send_char(CHAR_NEWLINE, 32'h0);
      settle();

      // directed, tiny area for wrap, scroll and backspace wrap-up
      write_cfg(12'd24, 12'd48, 12'd0, 12'd0);
      send_char(8'd65, 32'hA5A5_5A5A);
      send_char(8'd66, 32'h5A5A_A5A5);
      send_char(8'd67, 32'h1234_5678);
      send_char(CHAR_BACKSPACE, 32'h0);
      send_char(CHAR_NEWLINE, 32'h0);
      send_char(CHAR_NEWLINE, 32'h0);
      send_char(CHAR_BACKSPACE, 32'h0);
      send_char(CHAR_BACKSPACE, 32'h0);
      send_char(8'd90, 32'hFFFF_0000);
      settle();

      for (int p = 0; p < 7; p++) begin
         n_items = 75;
         send_calm = 1'b0;
         recv_calm = 1'b0;
         case (p)
            0: begin
               w = 12'd64; h = 12'd96; ox = 12'd8; oy = 12'd16;
            end
            1: begin
               w = 12'd0; h = 12'd0; ox = 12'd0; oy = 12'd4095;
            end
            2: begin
               w = 12'd4095; h = 12'd4095; ox = 12'd4095; oy = 12'd0;
            end
            3: begin
               w = 12'd40; h = 12'd80; ox = 12'd0; oy = 12'd0;
            end
            4: begin
               w = 12'd4095; h = 12'd4095; ox = 12'd0; oy = 12'd0;
            end
            5: begin
               w = 12'd200; h = 12'd160; ox = 12'd16; oy = 12'd32;
            end
            default: begin
               w = COORD_W'($urandom_range(4095));
               h = COORD_W'($urandom_range(4095));
               ox = COORD_W'($urandom_range(4095));
               oy = COORD_W'($urandom_range(4095));
            end
         endcase
         write_cfg(w, h, ox, oy);
         if (p == 0) begin
            send_calm = 1'b1;
            holds_asked++;
         end
         if (p == 3) begin
            send_calm = 1'b1;
            recv_calm = 1'b1;
         end
         repeat (n_items) send_char(pick_char(), $urandom());
         settle();
      end

      if (mismatches == 0 && cmds_due == 0) begin
         $display("PASS text_console_cursor_control_core");
      end else begin
         $display("FAIL text_console_cursor_control_core");
      end
      $finish;
   end

endmodule
